@@ src/aosks_pkg.sv @@
// Shared types and codes for the append-only slot key store.
package aosks_pkg;

  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int RANK_W = 6;
  localparam int KIND_W = 3;
  localparam int RES_W  = 2;

  // Operation kinds
  localparam logic [KIND_W-1:0] KIND_SET    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_GET    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_COUNT  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_RANK   = 3'd5;

  // Result status codes
  localparam logic [RES_W-1:0] RES_OK    = 2'd0;
  localparam logic [RES_W-1:0] RES_FULL  = 2'd1;
  localparam logic [RES_W-1:0] RES_NOKEY = 2'd2;
  localparam logic [RES_W-1:0] RES_RANK  = 2'd3;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_USE     = 2'd1,
    SLOT_REMOVED = 2'd2
  } slot_st_t;

  typedef struct packed {
    slot_st_t           status;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
  } slot_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [RANK_W-1:0]  rank;
  } op_t;

  typedef struct packed {
    logic start;
    logic step;
  } scan_ctl_t;

  typedef struct packed {
    logic [RES_W-1:0]  status;
    logic [VAL_W-1:0]  data;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_DONE = 2'd2
  } state_t;

endpackage

@@ src/aosks_cell.sv @@
// One slot of the rotating slot ring: status, key and value registers.
module aosks_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift,
  input  aosks_pkg::slot_t d,
  output aosks_pkg::slot_t q
);

  aosks_pkg::slot_st_t          status_r;
  logic [aosks_pkg::KEY_W-1:0]  key_r;
  logic [aosks_pkg::VAL_W-1:0]  value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= aosks_pkg::SLOT_EMPTY;
    end else if (shift) begin
      status_r <= d.status;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      key_r   <= d.key;
      value_r <= d.value;
    end
  end

  assign q.status = status_r;
  assign q.key    = key_r;
  assign q.value  = value_r;

endmodule

@@ src/aosks_scan.sv @@
// Head unit of the ring: updates the slot passing the head and keeps scan results.
module aosks_scan #(
  parameter int SLOTS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  aosks_pkg::scan_ctl_t ctl,
  input  aosks_pkg::op_t       op,
  input  aosks_pkg::slot_t     head,
  output aosks_pkg::slot_t     wb,
  output aosks_pkg::res_t      res
);

  localparam int CW   = $clog2(SLOTS + 1);
  localparam int CMPW = (CW > aosks_pkg::RANK_W) ? CW : aosks_pkg::RANK_W;

  logic                         hit_r, hit_nxt;
  logic                         fill_r, fill_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [aosks_pkg::VAL_W-1:0]  data_r, data_nxt;

  logic is_use;
  logic is_empty;
  logic match;
  logic rank_eq;

  assign is_use   = (head.status == aosks_pkg::SLOT_USE);
  assign is_empty = (head.status == aosks_pkg::SLOT_EMPTY);
  assign match    = is_use && (head.key == op.key);
  assign rank_eq  = (CMPW'(cnt_r) == CMPW'(op.rank));

  always_comb begin
    wb       = head;
    hit_nxt  = hit_r;
    fill_nxt = fill_r;
    cnt_nxt  = cnt_r;
    data_nxt = data_r;
    case (op.kind)
      aosks_pkg::KIND_SET: begin
        // tombstone first live match; fill first originally empty slot
        if (match && !hit_r) begin
          wb.status = aosks_pkg::SLOT_REMOVED;
          hit_nxt   = 1'b1;
        end else if (is_empty && !fill_r) begin
          wb.status = aosks_pkg::SLOT_USE;
          wb.key    = op.key;
          wb.value  = op.value;
          fill_nxt  = 1'b1;
        end
      end
      aosks_pkg::KIND_GET: begin
        if (match && !hit_r) begin
          hit_nxt  = 1'b1;
          data_nxt = head.value;
        end
      end
      aosks_pkg::KIND_REMOVE: begin
        if (match && !hit_r) begin
          wb.status = aosks_pkg::SLOT_REMOVED;
          hit_nxt   = 1'b1;
        end
      end
      aosks_pkg::KIND_CLEAR: begin
        wb.status = aosks_pkg::SLOT_EMPTY;
      end
      aosks_pkg::KIND_COUNT: begin
        if (is_use) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      aosks_pkg::KIND_RANK: begin
        if (is_use && !hit_r) begin
          if (rank_eq) begin
            hit_nxt  = 1'b1;
            data_nxt = head.key;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      fill_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctl.start) begin
      hit_r  <= 1'b0;
      fill_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctl.step) begin
      hit_r  <= hit_nxt;
      fill_r <= fill_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      data_r <= '0;
    end else if (ctl.step) begin
      data_r <= data_nxt;
    end
  end

  always_comb begin
    res.status = aosks_pkg::RES_OK;
    res.data   = '0;
    case (op.kind)
      aosks_pkg::KIND_SET: begin
        if (!fill_r) begin
          res.status = aosks_pkg::RES_FULL;
        end
      end
      aosks_pkg::KIND_GET: begin
        if (hit_r) begin
          res.data = data_r;
        end else begin
          res.status = aosks_pkg::RES_NOKEY;
        end
      end
      aosks_pkg::KIND_REMOVE: begin
        if (!hit_r) begin
          res.status = aosks_pkg::RES_NOKEY;
        end
      end
      aosks_pkg::KIND_COUNT: begin
        res.data = aosks_pkg::VAL_W'(cnt_r);
      end
      aosks_pkg::KIND_RANK: begin
        if (hit_r) begin
          res.data = data_r;
        end else begin
          res.status = aosks_pkg::RES_RANK;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ src/append_only_slot_key_store.sv @@
// Each accepted item starts a scan of the slot ring; the slot ring rotates once per item,
// one slot through the head unit each cycle, for every kind of operation. The result is
// then loaded into the output register once it is free; no new item is taken meanwhile.
// The input is taken again while a finished result waits in the output register.
// Reset (rst_n low, synchronous) empties every slot at once and idles the control.
module append_only_slot_key_store #(
  parameter int SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // key [31:0], value [63:32], rank [69:64], zero pad
  input  logic [2:0]  in_tuser,   // kind [2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // data [31:0]
  output logic [1:0]  out_tuser   // status [1:0]
);

  localparam int IW = $clog2(SLOTS);

  aosks_pkg::state_t    state_r, state_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  aosks_pkg::op_t       op_r;
  logic                 out_tvalid_r, out_tvalid_nxt;
  aosks_pkg::res_t      out_res_r;

  logic                 accept;
  logic                 last;
  logic                 load;
  aosks_pkg::scan_ctl_t ctl;
  aosks_pkg::slot_t     wb;
  aosks_pkg::res_t      res;
  aosks_pkg::slot_t     cell_d [SLOTS];
  aosks_pkg::slot_t     cell_q [SLOTS];

  assign accept = in_tvalid && in_tready;
  assign last   = (idx_r == IW'(SLOTS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      aosks_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = aosks_pkg::ST_SCAN;
          idx_nxt   = '0;
        end
      end
      aosks_pkg::ST_SCAN: begin
        idx_nxt = idx_r + 1'b1;
        if (last) begin
          state_nxt = aosks_pkg::ST_DONE;
        end
      end
      aosks_pkg::ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = aosks_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = aosks_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_tready = 1'b0;
    ctl.start = 1'b0;
    ctl.step  = 1'b0;
    load      = 1'b0;
    case (state_r)
      aosks_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        ctl.start = in_tvalid;
      end
      aosks_pkg::ST_SCAN: begin
        ctl.step = 1'b1;
      end
      aosks_pkg::ST_DONE: begin
        load = !out_tvalid_r || out_tready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aosks_pkg::ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r.kind  <= in_tuser;
      op_r.key   <= in_tdata[31:0];
      op_r.value <= in_tdata[63:32];
      op_r.rank  <= in_tdata[69:64];
    end
  end

  // ring: slot 0 sits at the head, the rewritten head enters at the tail
  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      if (g == SLOTS - 1) begin : g_tail
        assign cell_d[g] = wb;
      end else begin : g_body
        assign cell_d[g] = cell_q[g+1];
      end
      aosks_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (ctl.step),
        .d     (cell_d[g]),
        .q     (cell_q[g])
      );
    end
  endgenerate

  aosks_scan #(
    .SLOTS (SLOTS)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .op    (op_r),
    .head  (cell_q[0]),
    .wb    (wb),
    .res   (res)
  );

  // output register: hold until the beat is taken
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_res_r.data;
  assign out_tuser  = out_res_r.status;

`ifndef SYNTH
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == aosks_pkg::ST_SCAN) && (idx_r == '0))
    else $error("accepted beat did not start a scan at slot zero");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aosks_pkg::ST_SCAN) && last |=> (state_r == aosks_pkg::ST_DONE))
    else $error("scan did not end after the last slot");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != aosks_pkg::ST_IDLE) |-> !in_tready)
    else $error("input ready while an item is in work");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_tvalid_r)
    else $error("loaded result not presented");

  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aosks_pkg::ST_DONE) && !load |=> (state_r == aosks_pkg::ST_DONE))
    else $error("result dropped while output register was full");
`endif

endmodule
